### design/mlss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlss_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_OWNER_ID        = 3'd0;
  localparam logic [2:0] REG_RESET_CMD       = 3'd1;
  localparam logic [2:0] REG_DIGEST_CMD      = 3'd2;
  localparam logic [2:0] REG_INFO_CMD        = 3'd3;
  localparam logic [2:0] REG_FIRST_INFO_SEL  = 3'd4;
  localparam logic [2:0] REG_SECOND_INFO_SEL = 3'd5;

  // Action codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_SEND = 2'd2;

  // Command byte markers reported by the link
  localparam logic [7:0] SEEN_CLEARED = 8'd0;
  localparam logic [7:0] SEEN_INVALID = 8'hFF;

  typedef enum logic [3:0] {
    PH_RESET       = 4'd0,
    PH_CLAIM       = 4'd1,
    PH_READ_STATUS = 4'd2,
    PH_WAIT_STATUS = 4'd3,
    PH_WAIT_RESET  = 4'd4,
    PH_WAIT_DIGEST = 4'd5,
    PH_WAIT_INFO1  = 4'd6,
    PH_WAIT_INFO2  = 4'd7,
    PH_CONFIRM     = 4'd8,
    PH_FINISH      = 4'd9,
    PH_DONE        = 4'd10
  } phase_t;

  // Register file contents handed to the sequencer
  typedef struct packed {
    logic [7:0] owner_id;
    logic [7:0] reset_cmd;
    logic [7:0] digest_cmd;
    logic [7:0] info_cmd;
    logic [7:0] first_info_sel;
    logic [7:0] second_info_sel;
  } cfg_t;

  // One poll tick
  typedef struct packed {
    logic       restart;
    logic       status_pending;
    logic [7:0] seen_command;
    logic       reply_ready;
  } tick_t;

  // One result
  typedef struct packed {
    logic [1:0] action_kind;
    logic [7:0] command_out;
    logic [7:0] selector_out;
    logic       claim_pulse;
    logic       release_pulse;
    logic       busy_flag;
    logic       done_flag;
    logic [3:0] current_phase;
  } res_t;

endpackage

`default_nettype wire

### design/mlss_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module mlss_cfg
  import mlss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  // Register file; writes to unused indexes fall through the default arm
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWNER_ID:        cfg.owner_id        <= cfg_data;
        REG_RESET_CMD:       cfg.reset_cmd       <= cfg_data;
        REG_DIGEST_CMD:      cfg.digest_cmd      <= cfg_data;
        REG_INFO_CMD:        cfg.info_cmd        <= cfg_data;
        REG_FIRST_INFO_SEL:  cfg.first_info_sel  <= cfg_data;
        REG_SECOND_INFO_SEL: cfg.second_info_sel <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/mlss_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mlss_step
  import mlss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire tick_t tick,
  input  wire cfg_t  cfg,
  output res_t       res
);

  phase_t phase, phase_next;
  logic   holding, holding_next;
  logic   finished, finished_next;

  // Phase decode for one tick
  always_comb begin
    phase_t ph;
    logic   hold_v;
    logic   fin_v;
    ph     = phase;
    hold_v = holding;
    fin_v  = finished;
    res    = '0;
    // restart clears state, then the reset phase runs in the same tick
    if (tick.restart) begin
      ph     = PH_RESET;
      hold_v = 1'b0;
      fin_v  = 1'b0;
    end
    phase_next = ph;
    case (ph)
      PH_RESET: begin
        res.release_pulse = 1'b1;
        phase_next        = PH_CLAIM;
      end
      PH_CLAIM: begin
        res.claim_pulse = 1'b1;
        hold_v          = 1'b1;
        phase_next      = PH_READ_STATUS;
      end
      PH_READ_STATUS: begin
        res.action_kind = ACT_READ;
        phase_next      = PH_WAIT_STATUS;
      end
      PH_WAIT_STATUS: begin
        if (!tick.status_pending) begin
          res.action_kind = ACT_SEND;
          res.command_out = cfg.reset_cmd;
          phase_next      = PH_WAIT_RESET;
        end
      end
      PH_WAIT_RESET: begin
        if (tick.seen_command == SEEN_CLEARED) begin
          res.action_kind = ACT_SEND;
          res.command_out = cfg.digest_cmd;
          phase_next      = PH_WAIT_DIGEST;
        end
      end
      PH_WAIT_DIGEST: begin
        if (tick.reply_ready) begin
          res.action_kind  = ACT_SEND;
          res.command_out  = cfg.info_cmd;
          res.selector_out = cfg.first_info_sel;
          phase_next       = PH_WAIT_INFO1;
        end
      end
      PH_WAIT_INFO1: begin
        if (tick.reply_ready) begin
          res.action_kind  = ACT_SEND;
          res.command_out  = cfg.info_cmd;
          res.selector_out = cfg.second_info_sel;
          phase_next       = PH_WAIT_INFO2;
        end
      end
      PH_WAIT_INFO2: begin
        if (tick.reply_ready && tick.seen_command != SEEN_INVALID) begin
          phase_next = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (tick.reply_ready) begin
          phase_next = PH_FINISH;
        end
      end
      PH_FINISH: begin
        res.release_pulse = 1'b1;
        hold_v            = 1'b0;
        fin_v             = 1'b1;
        phase_next        = PH_DONE;
      end
      default: ;  // done and unreachable codes hold with no action
    endcase
    holding_next      = hold_v;
    finished_next     = fin_v;
    res.busy_flag     = hold_v;
    res.done_flag     = fin_v;
    res.current_phase = phase_next;
  end

  // Sequencer state advances on each transferred tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RESET;
      holding  <= 1'b0;
      finished <= 1'b0;
    end else if (fire) begin
      phase    <= phase_next;
      holding  <= holding_next;
      finished <= finished_next;
    end
  end

endmodule

`default_nettype wire

### design/motor_link_startup_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: each tick passes the input register, the phase decode and then the result register.
// Throughput: one poll tick per cycle while the result stream is not stalled, set by the
// single phase decode between the two registers; while a result waits, the input register
// takes at most one more tick.
// Reset (rst, synchronous): phase to reset, holding and finished cleared, all
// configuration registers to 0, both stream stages emptied.

module motor_link_startup_sequencer
  import mlss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // poll tick stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [0] restart, [1] status_pending, [9:2] seen_command, [10] reply_ready, [15:11] zero
  input  wire logic [15:0] s_tdata,
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] command_out, [15:8] selector_out, [16] claim_pulse, [17] release_pulse,
  // [18] busy_flag, [19] done_flag, [23:20] current_phase
  output logic [23:0]      m_tdata,
  // [1:0] action_kind
  output logic [1:0]       m_tuser
);

  cfg_t  cfg;
  tick_t tick;
  res_t  res;
  res_t  res_q;
  logic  tick_valid;
  logic  out_free;
  logic  fire;

  mlss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage handshake: a tick is processed when the result register can take it
  assign out_free = !m_tvalid || m_tready;
  assign fire     = tick_valid && out_free;
  assign s_tready = !tick_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (s_tready) begin
      tick_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      tick.restart        <= s_tdata[0];
      tick.status_pending <= s_tdata[1];
      tick.seen_command   <= s_tdata[9:2];
      tick.reply_ready    <= s_tdata[10];
    end
  end

  mlss_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .tick (tick),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.current_phase, res_q.done_flag, res_q.busy_flag,
                    res_q.release_pulse, res_q.claim_pulse,
                    res_q.selector_out, res_q.command_out};
  assign m_tuser = res_q.action_kind;

  // owner_id only tags transport claims outside this block
  logic [7:0] owner_unused;
  assign owner_unused = cfg.owner_id;

endmodule

`default_nettype wire
